### rtl/frlr_pkg.sv
// Shared types, constants and root table for the frame rate load regulator.
`default_nettype none

package frlr_pkg;

    localparam int LOAD_BITS = 20;
    localparam int STEPS     = 16;                 // fraction bits per log/exp
    localparam int T_W       = LOAD_BITS + 22;     // frame target width

    localparam logic [2:0] CFG_BASE   = 3'd0;
    localparam logic [2:0] CFG_BOOST  = 3'd1;
    localparam logic [2:0] CFG_IHL    = 3'd2;
    localparam logic [2:0] CFG_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_SHRINK = 3'd4;

    localparam logic [1:0] CMD_RATIO  = 2'd0;
    localparam logic [1:0] CMD_PERIOD = 2'd1;
    localparam logic [1:0] CMD_ADJUST = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_MUL_X,
        OP_SET_X,
        OP_EXP_MUL,
        OP_EXP_ACC,
        OP_SET_DECAY,
        OP_MUL_K,
        OP_SET_K,
        OP_LOG_SQ,
        OP_LOG_ACC,
        OP_MUL_Y,
        OP_SET_Y,
        OP_SET_FACTOR,
        OP_MUL_T1,
        OP_ACC_T1,
        OP_MUL_T2,
        OP_ACC_T2,
        OP_MUL_G,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    typedef logic [STEPS-1:0][30:0] t_root_tab;

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = 64'd0;
        bit_w = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bit_w > v) begin
                bit_w = bit_w >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bit_w != 64'd0) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-i), i = 1..STEPS, Q1.30, by repeated square roots of 2.0
    function automatic t_root_tab root_table();
        logic [63:0] root;
        t_root_tab   tab;
        root = 64'd2 << 30;
        for (int i = 0; i < STEPS; i++) begin
            root   = isqrt64(root << 30);
            tab[i] = root[30:0];
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

### rtl/frlr_ctrl.sv
// Sequencer for the regulator: walks the datapath through one adjust.
`default_nettype none

module frlr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic [1:0]         i_command,
    input  frlr_pkg::t_dp_stat      i_stat,
    output logic                    o_in_ready,
    output frlr_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_X,
        S_SET_X,
        S_EXP_MUL,
        S_EXP_ACC,
        S_SET_DECAY,
        S_MUL_K,
        S_SET_K,
        S_LOG_SQ,
        S_LOG_ACC,
        S_MUL_Y,
        S_SET_Y,
        S_SET_FACTOR,
        S_MUL_T1,
        S_ACC_T1,
        S_MUL_T2,
        S_ACC_T2,
        S_MUL_G,
        S_FIN
    } t_state;

    localparam logic [3:0] STEP_LAST = 4'(frlr_pkg::STEPS - 1);

    t_state     r_state;
    logic [3:0] r_step;
    logic       r_second;   // second exp pass (frame factor)

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.step = r_step;
        case (r_state)
            S_IDLE:       o_cmd.op = i_in_valid ? frlr_pkg::OP_ACCEPT : frlr_pkg::OP_NOP;
            S_MUL_X:      o_cmd.op = frlr_pkg::OP_MUL_X;
            S_SET_X:      o_cmd.op = frlr_pkg::OP_SET_X;
            S_EXP_MUL:    o_cmd.op = frlr_pkg::OP_EXP_MUL;
            S_EXP_ACC:    o_cmd.op = frlr_pkg::OP_EXP_ACC;
            S_SET_DECAY:  o_cmd.op = frlr_pkg::OP_SET_DECAY;
            S_MUL_K:      o_cmd.op = frlr_pkg::OP_MUL_K;
            S_SET_K:      o_cmd.op = frlr_pkg::OP_SET_K;
            S_LOG_SQ:     o_cmd.op = frlr_pkg::OP_LOG_SQ;
            S_LOG_ACC:    o_cmd.op = frlr_pkg::OP_LOG_ACC;
            S_MUL_Y:      o_cmd.op = frlr_pkg::OP_MUL_Y;
            S_SET_Y:      o_cmd.op = frlr_pkg::OP_SET_Y;
            S_SET_FACTOR: o_cmd.op = frlr_pkg::OP_SET_FACTOR;
            S_MUL_T1:     o_cmd.op = frlr_pkg::OP_MUL_T1;
            S_ACC_T1:     o_cmd.op = frlr_pkg::OP_ACC_T1;
            S_MUL_T2:     o_cmd.op = frlr_pkg::OP_MUL_T2;
            S_ACC_T2:     o_cmd.op = frlr_pkg::OP_ACC_T2;
            S_MUL_G:      o_cmd.op = frlr_pkg::OP_MUL_G;
            S_FIN:        o_cmd.op = i_stat.out_free ? frlr_pkg::OP_FIN : frlr_pkg::OP_NOP;
            default:      o_cmd.op = frlr_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= 4'd0;
            r_second <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_command == frlr_pkg::CMD_ADJUST) begin
                        r_state <= S_MUL_X;
                    end
                end
                S_MUL_X: r_state <= S_SET_X;
                S_SET_X: begin
                    r_state  <= S_EXP_MUL;
                    r_step   <= 4'd0;
                    r_second <= 1'b0;
                end
                S_EXP_MUL: r_state <= S_EXP_ACC;
                S_EXP_ACC: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == STEP_LAST) begin
                        r_state <= r_second ? S_SET_FACTOR : S_SET_DECAY;
                    end else begin
                        r_state <= S_EXP_MUL;
                    end
                end
                S_SET_DECAY: r_state <= S_MUL_K;
                S_MUL_K:     r_state <= S_SET_K;
                S_SET_K: begin
                    r_state <= S_LOG_SQ;
                    r_step  <= 4'd0;
                end
                S_LOG_SQ: r_state <= S_LOG_ACC;
                S_LOG_ACC: begin
                    r_step  <= r_step + 4'd1;
                    r_state <= (r_step == STEP_LAST) ? S_MUL_Y : S_LOG_SQ;
                end
                S_MUL_Y: r_state <= S_SET_Y;
                S_SET_Y: begin
                    r_state  <= S_EXP_MUL;
                    r_step   <= 4'd0;
                    r_second <= 1'b1;
                end
                S_SET_FACTOR: r_state <= S_MUL_T1;
                S_MUL_T1:     r_state <= S_ACC_T1;
                S_ACC_T1:     r_state <= S_MUL_T2;
                S_MUL_T2:     r_state <= S_ACC_T2;
                S_ACC_T2:     r_state <= S_MUL_G;
                S_MUL_G:      r_state <= S_FIN;
                S_FIN: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/frlr_dp.sv
// Datapath: sample peaks, config registers, shared multiplier, log/exp registers.
`default_nettype none

module frlr_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  frlr_pkg::t_dp_cmd                   i_cmd,
    output frlr_pkg::t_dp_stat                  o_stat,
    input  wire logic                           i_cfg_we,
    input  wire logic [2:0]                     i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data,
    input  wire logic [1:0]                     i_command,
    input  wire logic [15:0]                    i_frame_ratio,
    input  wire logic [15:0]                    i_gen_period,
    input  wire logic [frlr_pkg::LOAD_BITS-1:0] i_current_load,
    input  wire logic [23:0]                    i_elapsed_time,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [frlr_pkg::LOAD_BITS-1:0]      o_new_load
);

    localparam int LB = frlr_pkg::LOAD_BITS;
    localparam int TW = frlr_pkg::T_W;
    localparam frlr_pkg::t_root_tab ROOTS = frlr_pkg::root_table();

    // config
    logic [15:0] r_base, r_boost, r_ihl, r_limit, r_shrink;
    // samples
    logic [15:0] r_ratio_peak, r_period_peak;
    logic        r_ratio_seen, r_period_seen;
    // working registers
    logic [LB-1:0] r_load;
    logic [23:0]   r_elapsed;
    logic [63:0]   r_prod;
    logic [30:0]   r_er;       // exp accumulator, Q1.30
    logic [15:0]   r_exp_f;
    logic [5:0]    r_sh;
    logic          r_left, r_zero;
    logic [16:0]   r_decay;
    logic [17:0]   r_k;
    logic [30:0]   r_m;        // log mantissa, Q1.30
    logic [3:0]    r_lint;
    logic [15:0]   r_lfrac;
    logic [36:0]   r_factor;
    logic [TW-1:0] r_t;
    logic          r_out_valid;
    logic [LB-1:0] r_out;

    logic [31:0] mul_a, mul_b;
    logic        mul_en;

    // log magnitude
    logic [19:0] l_val, l_mag;
    logic        l_neg;
    assign l_val = {r_lint, r_lfrac};
    assign l_neg = r_lint[3];
    assign l_mag = l_neg ? (20'd0 - l_val) : l_val;

    always_comb begin
        mul_en = 1'b1;
        mul_a  = 32'd0;
        mul_b  = 32'd0;
        case (i_cmd.op)
            frlr_pkg::OP_MUL_X: begin
                mul_a = 32'(r_elapsed);
                mul_b = 32'(r_ihl);
            end
            frlr_pkg::OP_EXP_MUL: begin
                mul_a = 32'(r_er);
                mul_b = 32'(ROOTS[i_cmd.step]);
            end
            frlr_pkg::OP_MUL_K: begin
                mul_a = 32'(r_boost);
                mul_b = 32'(r_decay);
            end
            frlr_pkg::OP_LOG_SQ: begin
                mul_a = 32'(r_m);
                mul_b = 32'(r_m);
            end
            frlr_pkg::OP_MUL_Y: begin
                mul_a = 32'(r_k);
                mul_b = 32'(l_mag);
            end
            frlr_pkg::OP_MUL_T1: begin
                mul_a = 32'(r_load);
                mul_b = 32'(r_factor[36:16]);
            end
            frlr_pkg::OP_MUL_T2: begin
                mul_a = 32'(r_load);
                mul_b = 32'(r_factor[15:0]);
            end
            frlr_pkg::OP_MUL_G: begin
                mul_a = 32'(r_load);
                mul_b = 32'(r_shrink);
            end
            default: mul_en = 1'b0;
        endcase
    end

    // decay exponent setup: 2^-x, x = elapsed*ihl in Q16
    logic [31:0] x_val;
    logic [16:0] x_sh;
    assign x_val = r_prod[39:8];
    assign x_sh  = 17'(x_val[31:16]) + 17'(x_val[15:0] != 16'd0);

    // frame exponent setup: y = floor(-(k*L) / 2^16)
    logic [22:0] y_dn, y_up;
    logic [23:0] y_val;
    logic [7:0]  y_n, y_nn;
    assign y_dn  = {1'b0, r_prod[37:16]};
    assign y_up  = y_dn + 23'(r_prod[15:0] != 16'd0);
    assign y_val = l_neg ? {1'b0, y_dn} : (24'd0 - {1'b0, y_up});
    assign y_n   = y_val[23:16];
    assign y_nn  = 8'd0 - y_n;

    // log normalization
    logic [3:0]  msb_p;
    always_comb begin
        msb_p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (r_ratio_peak[i]) begin
                msb_p = 4'(i);
            end
        end
    end

    logic [31:0] sq;
    assign sq = r_prod[61:30];

    logic [16:0] exp_e;
    assign exp_e = r_er[30:14];

    // final selection
    logic [TW-1:0] load_w, frame_a;
    logic [LB-1:0] gen_v, gen_b, res;
    assign load_w = TW'(r_load);
    always_comb begin
        if (!r_ratio_seen) begin
            frame_a = load_w;
        end else if (r_ratio_peak == 16'd0 || r_t == load_w) begin
            frame_a = load_w + TW'(1);
        end else begin
            frame_a = r_t;
        end
        gen_v = r_prod[LB+15:16];
        if (!r_period_seen || r_period_peak < r_limit) begin
            gen_b = '1;
        end else if (gen_v == '0) begin
            gen_b = '0;
        end else begin
            gen_b = gen_v - LB'(1);
        end
        res = (frame_a < TW'(gen_b)) ? frame_a[LB-1:0] : gen_b;
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_new_load      = r_out;

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.op)
            frlr_pkg::OP_ACCEPT: begin
                r_load    <= i_current_load;
                r_elapsed <= i_elapsed_time;
            end
            frlr_pkg::OP_SET_X: begin
                r_er    <= 31'd1 << 30;
                r_exp_f <= 16'd0 - x_val[15:0];
                r_left  <= 1'b0;
                r_zero  <= (x_sh >= 17'd40);
                r_sh    <= x_sh[5:0];
            end
            frlr_pkg::OP_EXP_ACC: begin
                if (r_exp_f[~i_cmd.step]) begin
                    r_er <= r_prod[60:30];
                end
            end
            frlr_pkg::OP_SET_DECAY: begin
                r_decay <= r_zero ? 17'd0 : (exp_e >> r_sh);
            end
            frlr_pkg::OP_SET_K: begin
                r_k     <= 18'(r_base) + 18'(r_prod[32:16]);
                r_m     <= 31'(r_ratio_peak) << (5'd30 - {1'b0, msb_p});
                r_lint  <= msb_p - 4'd8;
                r_lfrac <= 16'd0;
            end
            frlr_pkg::OP_LOG_ACC: begin
                if (sq[31]) begin
                    r_m                <= sq[31:1];
                    r_lfrac[~i_cmd.step] <= 1'b1;
                end else begin
                    r_m <= sq[30:0];
                end
            end
            frlr_pkg::OP_SET_Y: begin
                r_er    <= 31'd1 << 30;
                r_exp_f <= y_val[15:0];
                if (!y_n[7]) begin
                    r_left <= 1'b1;
                    r_zero <= 1'b0;
                    r_sh   <= (y_n > 8'd20) ? 6'd20 : y_n[5:0];
                end else begin
                    r_left <= 1'b0;
                    r_zero <= (y_nn >= 8'd40);
                    r_sh   <= y_nn[5:0];
                end
            end
            frlr_pkg::OP_SET_FACTOR: begin
                if (r_zero) begin
                    r_factor <= 37'd0;
                end else if (r_left) begin
                    r_factor <= 37'(exp_e) << r_sh;
                end else begin
                    r_factor <= 37'(exp_e >> r_sh);
                end
            end
            frlr_pkg::OP_ACC_T1: r_t <= TW'(r_prod);
            frlr_pkg::OP_ACC_T2: r_t <= r_t + TW'(r_prod[LB+15:16]);
            frlr_pkg::OP_FIN:    r_out <= res;
            default: ;
        endcase
    end

    // control state: config, sample peaks, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= 16'd983;
            r_boost       <= 16'd3277;
            r_ihl         <= 16'd21845;
            r_limit       <= 16'd346;
            r_shrink      <= 16'd65372;
            r_ratio_peak  <= 16'd0;
            r_ratio_seen  <= 1'b0;
            r_period_peak <= 16'd0;
            r_period_seen <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    frlr_pkg::CFG_BASE:   r_base   <= i_cfg_data;
                    frlr_pkg::CFG_BOOST:  r_boost  <= i_cfg_data;
                    frlr_pkg::CFG_IHL:    r_ihl    <= i_cfg_data;
                    frlr_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data;
                    frlr_pkg::CFG_SHRINK: r_shrink <= i_cfg_data;
                    default: ;
                endcase
            end
            // a new result may load in the same cycle the old one transfers
            if (i_cmd.op == frlr_pkg::OP_FIN) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                frlr_pkg::OP_ACCEPT: begin
                    if (i_command == frlr_pkg::CMD_RATIO) begin
                        r_ratio_seen <= 1'b1;
                        if (i_frame_ratio > r_ratio_peak) begin
                            r_ratio_peak <= i_frame_ratio;
                        end
                    end else if (i_command == frlr_pkg::CMD_PERIOD) begin
                        r_period_seen <= 1'b1;
                        if (i_gen_period > r_period_peak) begin
                            r_period_peak <= i_gen_period;
                        end
                    end
                end
                frlr_pkg::OP_FIN: begin
                    r_ratio_peak  <= 16'd0;
                    r_ratio_seen  <= 1'b0;
                    r_period_peak <= 16'd0;
                    r_period_seen <= 1'b0;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/frame_rate_load_regulator.sv
// Top level of the frame rate load regulator: sequencer plus datapath.
`default_nettype none

// Recommends a new load count from the worst frame ratio and worst generation
// period seen since the last adjust. Sample transfers (command 0 or 1) are
// accepted while idle and produce no result. An adjust transfer (command 2)
// runs a fixed sequence of steps through one shared 32x32 multiplier: the boost
// decay 2^-x (16 root products), the log2 of the ratio peak (16 squarings) and
// the frame factor 2^y (16 more root products), each step a multiply followed
// by an update. The result sits in an output register; the next item is taken
// as soon as the sequence ends, even while the result still waits for its
// transfer. The last cycle of a sequence stalls while an earlier result has not
// yet been taken. Command 3 is accepted and ignored. Configuration writes are
// registered and are meant to happen only while the block is idle.
module frame_rate_load_regulator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_command,
    input  wire logic [15:0]                    i_frame_ratio,
    input  wire logic [15:0]                    i_gen_period,
    input  wire logic [frlr_pkg::LOAD_BITS-1:0] i_current_load,
    input  wire logic [23:0]                    i_elapsed_time,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [frlr_pkg::LOAD_BITS-1:0]      o_new_load,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [2:0]                     i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data
);

    frlr_pkg::t_dp_cmd  dp_cmd;
    frlr_pkg::t_dp_stat dp_stat;

    frlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    frlr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_frame_ratio   (i_frame_ratio),
        .i_gen_period    (i_gen_period),
        .i_current_load  (i_current_load),
        .i_elapsed_time  (i_elapsed_time),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_new_load      (o_new_load)
    );

endmodule

`default_nettype wire
